// File: design/mcrsc_pkg.sv
// ----------------------------------------------------------------------------
// Multi-channel run state controller package
// Shared types and codes for the channel state controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrsc_pkg;

	// Per-channel run state codes.
	typedef enum logic [2:0] {
		CH_DISABLED  = 3'd0,
		CH_IDLE      = 3'd1,
		CH_RUNNING   = 3'd2,
		CH_COMPLETED = 3'd3,
		CH_FAULT     = 3'd4
	} chst_t;

	// Command codes.
	typedef enum logic [1:0] {
		REQ_START    = 2'd0,
		REQ_COMPLETE = 2'd1,
		REQ_SET_FLT  = 2'd2,
		REQ_CLR_FLT  = 2'd3
	} req_t;

	// Result codes.
	typedef enum logic [2:0] {
		RC_OK      = 3'd0,
		RC_PARTIAL = 3'd1,
		RC_BUSY    = 3'd2,
		RC_FAULT   = 3'd3,
		RC_NOTCONF = 3'd4,
		RC_INVALID = 3'd5
	} rc_t;

	// Summarized device state.
	typedef enum logic [1:0] {
		DEV_IDLE     = 2'd0,
		DEV_RUNNING  = 2'd1,
		DEV_DEGRADED = 2'd2,
		DEV_FAULT    = 2'd3
	} dev_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_INSTALLED = 2'd0;
	localparam logic [1:0] CFG_ENABLED   = 2'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the command transaction
		logic exec;    // execute the captured command
		logic cfg_we;  // configuration transaction
	} dp_cmd_t;

endpackage

`default_nettype wire

// File: design/multi_channel_run_state_controller.sv
// A command accepted on start is captured, then evaluated in S_EXEC; done rises in S_RESP.
// A new command is taken only in S_IDLE, so capture, execute and response never overlap.
// The receiver cannot stall; each result is registered and held until the next execute.
// Reset clears both masks, so every channel starts disabled; results are not reset.
// Any write to a listed configuration register re-initializes all channel states.
// ----------------------------------------------------------------------------
// Multi-channel run state controller
// Tracks the run state of up to eight actuator channels and executes
// start, complete, set fault and clear fault commands.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_run_state_controller #(
	parameter int CHANNELS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  channel_mask,
	input  wire logic [7:0]  channel_index,
	// Result channel
	output logic             done,
	output logic [2:0]       result_code,
	output logic [7:0]       success_mask,
	output logic [7:0]       busy_mask,
	output logic [7:0]       fault_mask,
	output logic [7:0]       skipped_mask,
	output logic [7:0]       running_mask,
	output logic [7:0]       faulted_mask,
	output logic [3:0]       running_count,
	output logic [1:0]       device_state,
	output logic [2:0]       addressed_state,
	// Configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	mcrsc_pkg::dp_cmd_t cmd;

	// Sequencer.
	mcrsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.busy      (busy),
		.done      (done),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// Datapath.
	mcrsc_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_type        (req_type),
		.channel_mask    (channel_mask),
		.channel_index   (channel_index),
		.result_code     (result_code),
		.success_mask    (success_mask),
		.busy_mask       (busy_mask),
		.fault_mask      (fault_mask),
		.skipped_mask    (skipped_mask),
		.running_mask    (running_mask),
		.faulted_mask    (faulted_mask),
		.running_count   (running_count),
		.device_state    (device_state),
		.addressed_state (addressed_state)
	);

endmodule

`default_nettype wire

// File: design/mcrsc_ctrl.sv
// ----------------------------------------------------------------------------
// Command sequencer
// Steps each command through capture, execute and response.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrsc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             cfg_valid,
	output logic                  busy,
	output logic                  done,
	output logic                  cfg_ready,
	output mcrsc_pkg::dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;

	// State register and the response strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_RESP;
					done    <= 1'b1;
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Handshake outputs and datapath commands. A command transaction takes
	// precedence, so a configuration write never lands with a command.
	always_comb begin
		busy       = (state_q != S_IDLE);
		cfg_ready  = (state_q == S_IDLE) && !start;
		cmd.load   = start && (state_q == S_IDLE);
		cmd.exec   = (state_q == S_EXEC);
		cmd.cfg_we = cfg_valid && cfg_ready;
	end

endmodule

`default_nettype wire

// File: design/mcrsc_dp.sv
// ----------------------------------------------------------------------------
// Channel state datapath
// Holds configuration and per-channel states and evaluates one command.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrsc_dp #(
	parameter int CHANNELS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mcrsc_pkg::dp_cmd_t cmd,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	input  wire logic [1:0]        req_type,
	input  wire logic [7:0]        channel_mask,
	input  wire logic [7:0]        channel_index,
	output logic [2:0]             result_code,
	output logic [7:0]             success_mask,
	output logic [7:0]             busy_mask,
	output logic [7:0]             fault_mask,
	output logic [7:0]             skipped_mask,
	output logic [7:0]             running_mask,
	output logic [7:0]             faulted_mask,
	output logic [3:0]             running_count,
	output logic [1:0]             device_state,
	output logic [2:0]             addressed_state
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [7:0] ALL_CH = 8'((16'd1 << CHANNELS) - 16'd1);

	logic [7:0]          installed_q;
	logic [7:0]          enabled_q;
	mcrsc_pkg::chst_t    chan_q [CHANNELS];

	mcrsc_pkg::req_t     req_q;
	logic [7:0]          mask_q;
	logic [7:0]          idx_q;

	// Effective masks and the re-initialization value after a config write.
	logic [7:0] inst_eff, en_eff, inst_new, en_new, en_init;
	logic       cfg_hit;

	always_comb begin
		inst_eff = installed_q & ALL_CH;
		en_eff   = enabled_q & inst_eff;
		inst_new = installed_q;
		en_new   = enabled_q;
		cfg_hit  = 1'b0;
		case (cfg_index)
			mcrsc_pkg::CFG_INSTALLED: begin
				inst_new = cfg_data;
				cfg_hit  = 1'b1;
			end
			mcrsc_pkg::CFG_ENABLED: begin
				en_new  = cfg_data;
				cfg_hit = 1'b1;
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
		en_init = en_new & inst_new & ALL_CH;
	end

	// Command evaluation on the captured transaction.
	mcrsc_pkg::chst_t nxt [CHANNELS];
	mcrsc_pkg::rc_t   rc;
	logic [7:0]       req_m, succ, bsy, flt, skip, run, fm;
	logic [3:0]       cnt;
	logic [IDX_W-1:0] idx_sel;
	logic             idx_range, idx_ok;
	mcrsc_pkg::dev_t  dev;
	mcrsc_pkg::chst_t addr_st;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			nxt[i] = chan_q[i];
		end
		rc        = mcrsc_pkg::RC_OK;
		succ      = '0;
		bsy       = '0;
		flt       = '0;
		skip      = '0;
		req_m     = mask_q & ALL_CH;
		idx_sel   = idx_q[IDX_W-1:0];
		idx_range = ({1'b0, idx_q} < 9'(CHANNELS));
		idx_ok    = idx_range && inst_eff[idx_q[2:0]];

		if (req_q == mcrsc_pkg::REQ_START) begin
			if (req_m == 8'd0) begin
				rc = mcrsc_pkg::RC_INVALID;
			end else begin
				skip = req_m & ~en_eff;
				for (int i = 0; i < CHANNELS; i++) begin
					if (req_m[i] && !skip[i]) begin
						if (chan_q[i] == mcrsc_pkg::CH_RUNNING) begin
							bsy[i] = 1'b1;
						end else if (chan_q[i] == mcrsc_pkg::CH_FAULT) begin
							flt[i] = 1'b1;
						end else begin
							nxt[i]  = mcrsc_pkg::CH_RUNNING;
							succ[i] = 1'b1;
						end
					end
				end
				if (succ != 8'd0 && (bsy != 8'd0 || flt != 8'd0 || skip != 8'd0))
					rc = mcrsc_pkg::RC_PARTIAL;
				else if (succ != 8'd0) rc = mcrsc_pkg::RC_OK;
				else if (flt != 8'd0)  rc = mcrsc_pkg::RC_FAULT;
				else if (bsy != 8'd0)  rc = mcrsc_pkg::RC_BUSY;
				else                   rc = mcrsc_pkg::RC_NOTCONF;
			end
		end else if (!idx_ok) begin
			rc = mcrsc_pkg::RC_INVALID;
		end else begin
			case (req_q)
				mcrsc_pkg::REQ_COMPLETE: begin
					if (chan_q[idx_sel] != mcrsc_pkg::CH_RUNNING)
						rc = mcrsc_pkg::RC_BUSY;
					else
						nxt[idx_sel] = mcrsc_pkg::CH_COMPLETED;
				end
				mcrsc_pkg::REQ_SET_FLT: begin
					if (!en_eff[idx_q[2:0]])
						rc = mcrsc_pkg::RC_NOTCONF;
					else
						nxt[idx_sel] = mcrsc_pkg::CH_FAULT;
				end
				default: begin
					if (chan_q[idx_sel] != mcrsc_pkg::CH_FAULT)
						rc = mcrsc_pkg::RC_INVALID;
					else
						nxt[idx_sel] = mcrsc_pkg::CH_IDLE;
				end
			endcase
		end

		// Summaries over the post-command states.
		run = '0;
		fm  = '0;
		cnt = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (nxt[i] == mcrsc_pkg::CH_RUNNING) begin
				run[i] = 1'b1;
				cnt    = cnt + 4'd1;
			end else if (nxt[i] == mcrsc_pkg::CH_FAULT) begin
				fm[i] = 1'b1;
			end
		end
		if (run != 8'd0)                                 dev = mcrsc_pkg::DEV_RUNNING;
		else if (en_eff == 8'd0 || (fm & en_eff) == en_eff) dev = mcrsc_pkg::DEV_FAULT;
		else if ((fm & en_eff) != 8'd0)                  dev = mcrsc_pkg::DEV_DEGRADED;
		else                                             dev = mcrsc_pkg::DEV_IDLE;

		addr_st = idx_range ? nxt[idx_sel] : mcrsc_pkg::CH_DISABLED;
	end

	// Configuration registers and the channel state store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			installed_q <= '0;
			enabled_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				chan_q[i] <= mcrsc_pkg::CH_DISABLED;
			end
		end else if (cmd.cfg_we && cfg_hit) begin
			installed_q <= inst_new;
			enabled_q   <= en_new;
			for (int i = 0; i < CHANNELS; i++) begin
				chan_q[i] <= en_init[i] ? mcrsc_pkg::CH_IDLE : mcrsc_pkg::CH_DISABLED;
			end
		end else if (cmd.exec) begin
			for (int i = 0; i < CHANNELS; i++) begin
				chan_q[i] <= nxt[i];
			end
		end
	end

	// Command capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= mcrsc_pkg::req_t'(req_type);
			mask_q <= channel_mask;
			idx_q  <= channel_index;
		end
	end

	// Result registers, shown while the strobe is high.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_code     <= rc;
			success_mask    <= succ;
			busy_mask       <= bsy;
			fault_mask      <= flt;
			skipped_mask    <= skip;
			running_mask    <= run;
			faulted_mask    <= fm;
			running_count   <= cnt;
			device_state    <= dev;
			addressed_state <= addr_st;
		end
	end

endmodule

`default_nettype wire
